/* rtl/dvr_pkg.sv */
// dvr_pkg: shared types and constants of the distance-vector route engine
// used by dvr_engine, dvr_out_reg and distance_vector_route_engine
package dvr_pkg;

  localparam int NUM_ROUTERS_DEF = 8;

  localparam int FIELD_W = 3;   // router index fields on the ports
  localparam int COST_W  = 10;  // cost field on the ports
  localparam int ENTRY_W = 11;  // one cost table entry
  localparam int SUM_W   = 12;  // entry plus entry

  localparam logic [COST_W-1:0]  INF_COST  = 10'd1000;
  localparam logic [ENTRY_W-1:0] INF_ENTRY = 11'd1000;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam logic [1:0] OP_LINK   = 2'd0;
  localparam logic [1:0] OP_VECTOR = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic KIND_ROUTE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] idx;
    logic [COST_W-1:0]  cost;   // already clamped to INF_COST
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] hop;
    logic [COST_W-1:0]  distance;
  } res_t;

endpackage

/* rtl/distance_vector_route_engine.sv */
// channel   dir  tdata (low bit up)                         side bits
// in_       in   source_router, entry_index, cost           tuser opcode, tlast last_entry
// out_      out  next_hop, distance, 3 zero bits            tuser result_kind
// cfg_      in   own_id                                     wr_en
//
// link cost writes, plain vector entries and ignored items are handled on acceptance.
// a route query holds the input through the own row copy and the scan, its answer then
// reaching the output register; a closing vector entry holds it through the own row copy
// and the relaxation scan of the one-read-a-cycle cost table memory, then signals done.
// after reset a clearing pass over all 2^(2*ceil(log2 N)) entries (64 for N=8) fills the
// table; no item is accepted during it. a finished result waits in the output
// register while the next item is taken; a further result waits in the engine.
// top level: own_id register, input clamping and port packing; uses dvr_pkg,
// dvr_engine and dvr_out_reg
module distance_vector_route_engine #(
  parameter int NUM_ROUTERS = dvr_pkg::NUM_ROUTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // source_router, entry_index, cost
  input  logic                        in_tlast,   // last_entry
  input  logic [1:0]                  in_tuser,   // opcode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // next_hop, distance, zero pad
  output logic                        out_tuser,  // result_kind
  input  logic                        cfg_wr_en,
  input  logic [dvr_pkg::FIELD_W-1:0] cfg_wr_data // own_id
);
  import dvr_pkg::*;

  logic [FIELD_W-1:0] own_id_r, own_id_nxt;
  logic [COST_W-1:0]  cost_raw;
  cmd_t               cmd;
  logic               res_valid, res_ready;
  res_t               res, out_res;

  assign own_id_nxt = cfg_wr_en ? cfg_wr_data : own_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else begin
      own_id_r <= own_id_nxt;
    end
  end

  assign cost_raw   = in_tdata[15:6];
  assign cmd.opcode = in_tuser;
  assign cmd.src    = in_tdata[2:0];
  assign cmd.idx    = in_tdata[5:3];
  assign cmd.cost   = (cost_raw > INF_COST) ? INF_COST : cost_raw;
  assign cmd.last   = in_tlast;

  dvr_engine #(
    .NUM_ROUTERS(NUM_ROUTERS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .own_id    (own_id_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dvr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'b000, out_res.distance, out_res.hop};
  assign out_tuser = out_res.kind;

endmodule

/* rtl/dvr_engine.sv */
// dvr_engine: cost table memory, own-row snapshot memory and the sequencer
// that writes entries, relaxes the own row and answers route queries; uses dvr_pkg
module dvr_engine #(
  parameter int NUM_ROUTERS = dvr_pkg::NUM_ROUTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dvr_pkg::FIELD_W-1:0] own_id,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dvr_pkg::cmd_t               cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output dvr_pkg::res_t               res
);
  import dvr_pkg::*;

  localparam int IDX_W   = (NUM_ROUTERS > 1) ? $clog2(NUM_ROUTERS) : 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int TBL_DEPTH  = 1 << ADDR_W;
  localparam int SNAP_DEPTH = 1 << IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ROUTERS - 1);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_CLEAR = 3'd0;
  localparam logic [STATE_W-1:0] S_IDLE  = 3'd1;
  localparam logic [STATE_W-1:0] S_COPY  = 3'd2;
  localparam logic [STATE_W-1:0] S_RELAX = 3'd3;
  localparam logic [STATE_W-1:0] S_QUERY = 3'd4;
  localparam logic [STATE_W-1:0] S_DONE  = 3'd5;

  logic [ENTRY_W-1:0] tbl_mem  [TBL_DEPTH];
  logic [ENTRY_W-1:0] snap_mem [SNAP_DEPTH];
  logic [ENTRY_W-1:0] tbl_rd_r, snap_rd_r;

  logic               tbl_we, snap_we;
  logic [ADDR_W-1:0]  tbl_waddr, tbl_raddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [IDX_W-1:0]   snap_raddr;

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               mode_q_r, mode_q_nxt;
  logic [IDX_W-1:0]   d_r, d_nxt;
  logic               up_r, up_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic               iss_r, iss_nxt;
  logic               p_vld_r, p_vld_nxt, p_end_r, p_end_nxt;
  logic [IDX_W-1:0]   p_i_r, p_i_nxt, p_j_r, p_j_nxt;
  logic [SUM_W-1:0]   best_r, best_nxt;
  logic [ENTRY_W-1:0] target_r, target_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   hop_r, hop_nxt;
  res_t               res_r, res_nxt;

  logic             in_fire, me_ok, idx_ok, src_ok, last_issue;
  logic [IDX_W-1:0] me, idx_i, src_i, jq;
  logic [SUM_W-1:0] sum, cand_path, cand_old, cand_min, base, new_best;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign me_ok  = 32'(own_id)  < NUM_ROUTERS;
  assign idx_ok = 32'(cmd.idx) < NUM_ROUTERS;
  assign src_ok = 32'(cmd.src) < NUM_ROUTERS;
  assign me     = IDX_W'(own_id);
  assign idx_i  = IDX_W'(cmd.idx);
  assign src_i  = IDX_W'(cmd.src);

  // query scans upward when the destination lies above own_id
  assign jq = up_r ? j_r : (LAST_IDX - j_r);
  assign last_issue = (j_r == LAST_IDX) && ((state_r != S_RELAX) || (i_r == LAST_IDX));

  // one relaxation step: path through j, and the old value when j meets i
  assign sum       = {1'b0, tbl_rd_r} + {1'b0, snap_rd_r};
  assign cand_path = (p_j_r != me) ? sum : SUM_MAX;
  assign cand_old  = (p_j_r == p_i_r) ? {1'b0, snap_rd_r} : SUM_MAX;
  assign cand_min  = (cand_path < cand_old) ? cand_path : cand_old;
  assign base      = (p_j_r == '0) ? SUM_MAX : best_r;
  assign new_best  = (cand_min < base) ? cand_min : base;

  always_comb begin
    state_nxt  = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mode_q_nxt = mode_q_r;
    d_nxt      = d_r;
    up_nxt     = up_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    iss_nxt    = iss_r;
    p_vld_nxt  = 1'b0;
    p_end_nxt  = 1'b0;
    p_i_nxt    = i_r;
    p_j_nxt    = j_r;
    best_nxt   = best_r;
    target_nxt = target_r;
    found_nxt  = found_r;
    hop_nxt    = hop_r;
    res_nxt    = res_r;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = '0;
    tbl_raddr  = '0;
    snap_raddr = '0;
    snap_we    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt_r;
        tbl_wdata = (clr_cnt_r[ADDR_W-1:IDX_W] == clr_cnt_r[IDX_W-1:0]) ? '0 : INF_ENTRY;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd.opcode)
            OP_LINK: begin
              if (me_ok && idx_ok && (cmd.idx != own_id)) begin
                tbl_we    = 1'b1;
                tbl_waddr = {me, idx_i};
                tbl_wdata = {1'b0, cmd.cost};
              end
            end
            OP_VECTOR: begin
              if (cmd.src != own_id) begin
                if (src_ok && idx_ok) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = {src_i, idx_i};
                  tbl_wdata = {1'b0, cmd.cost};
                end
                if (cmd.last) begin
                  res_nxt = '{kind: KIND_DONE, hop: '0, distance: '0};
                  if (me_ok) begin
                    state_nxt  = S_COPY;
                    mode_q_nxt = 1'b0;
                    i_nxt      = '0;
                    j_nxt      = '0;
                    iss_nxt    = 1'b1;
                  end else begin
                    state_nxt = S_DONE;
                  end
                end
              end
            end
            OP_QUERY: begin
              if (me_ok && idx_ok) begin
                state_nxt  = S_COPY;
                mode_q_nxt = 1'b1;
                d_nxt      = idx_i;
                up_nxt     = cmd.idx > own_id;
                i_nxt      = '0;
                j_nxt      = '0;
                iss_nxt    = 1'b1;
              end else begin
                res_nxt   = '{kind: KIND_ROUTE, hop: cmd.idx, distance: INF_COST};
                state_nxt = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_COPY, S_RELAX, S_QUERY: begin
        // read issue
        if (state_r == S_COPY) begin
          tbl_raddr = {me, j_r};
        end else if (state_r == S_RELAX) begin
          tbl_raddr  = {j_r, i_r};
          snap_raddr = j_r;
        end else begin
          tbl_raddr  = {jq, d_r};
          snap_raddr = jq;
        end
        p_vld_nxt = iss_r;
        p_end_nxt = iss_r && last_issue;
        p_j_nxt   = (state_r == S_QUERY) ? jq : j_r;
        if (iss_r) begin
          if (last_issue) begin
            iss_nxt = 1'b0;
          end
          if (j_r == LAST_IDX) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end

        // data returning from the memories
        if (p_vld_r) begin
          if (state_r == S_COPY) begin
            snap_we = 1'b1;
            if (p_j_r == d_r) begin
              target_nxt = tbl_rd_r;
            end
            if (p_end_r) begin
              state_nxt = mode_q_r ? S_QUERY : S_RELAX;
              i_nxt     = '0;
              j_nxt     = '0;
              iss_nxt   = 1'b1;
              found_nxt = 1'b0;
            end
          end else if (state_r == S_RELAX) begin
            best_nxt = new_best;
            if ((p_j_r == LAST_IDX) && (p_i_r != me)) begin
              tbl_we    = 1'b1;
              tbl_waddr = {me, p_i_r};
              tbl_wdata = ENTRY_W'(new_best);
            end
            if (p_end_r) begin
              state_nxt = S_DONE;
            end
          end else begin
            if (!found_r && (d_r != me) && (p_j_r != me) && (p_j_r != d_r) &&
                (sum == {1'b0, target_r})) begin
              found_nxt = 1'b1;
              hop_nxt   = p_j_r;
            end
            if (p_end_r) begin
              res_nxt.kind     = KIND_ROUTE;
              res_nxt.hop      = FIELD_W'(found_nxt ? hop_nxt : d_r);
              res_nxt.distance = target_r[COST_W-1:0];
              state_nxt        = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[p_j_r] <= tbl_rd_r;
    end
    snap_rd_r <= snap_mem[snap_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      iss_r     <= 1'b0;
      p_vld_r   <= 1'b0;
      p_end_r   <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      iss_r     <= iss_nxt;
      p_vld_r   <= p_vld_nxt;
      p_end_r   <= p_end_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_q_r <= mode_q_nxt;
    d_r      <= d_nxt;
    up_r     <= up_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    p_i_r    <= p_i_nxt;
    p_j_r    <= p_j_nxt;
    best_r   <= best_nxt;
    target_r <= target_nxt;
    hop_r    <= hop_nxt;
    res_r    <= res_nxt;
  end

`ifndef ASSERT_OFF
  a_relax_own_row: assert property (@(posedge clk) disable iff (!rst_n)
    (tbl_we && (state_r == S_RELAX)) |-> (tbl_waddr[ADDR_W-1:IDX_W] == me))
    else $error("relaxation wrote outside the own row");

  a_snap_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    snap_we |-> (state_r == S_COPY))
    else $error("snapshot written outside the copy phase");

  a_route_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind == KIND_ROUTE)) |-> (res.distance <= INF_COST))
    else $error("route answer distance above infinity");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind == KIND_DONE)) |-> ((res.hop == '0) && (res.distance == '0)))
    else $error("relaxation result carries non-zero payload");
`endif

endmodule

/* rtl/dvr_out_reg.sv */
// dvr_out_reg: output register holding one finished result until the
// result channel takes it; uses dvr_pkg
module dvr_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_ready,
  input  dvr_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_ready,
  output dvr_pkg::res_t out_res
);
  import dvr_pkg::*;

  logic vld_r, vld_nxt;
  res_t data_r, data_nxt;

  assign res_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = data_r;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (res_valid && res_ready) begin
      vld_nxt  = 1'b1;
      data_nxt = res;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* bench/dvr_route_checker.sv */
// dvr_route_checker: watches the command, result and own_id channels of the route engine,
// keeps its own cost table and queue of expected results, and counts mismatches
// depends on dvr_pkg for field widths, opcodes and result kinds
module dvr_route_checker
  import dvr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [15:0]        in_tdata,   // source_router, entry_index, cost
  input  logic               in_tlast,   // last_entry
  input  logic [1:0]         in_tuser,   // opcode
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [15:0]        out_tdata,  // next_hop, distance, zero pad
  input  logic               out_tuser,  // result_kind
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data, // own_id
  output int                 mismatches,
  output int                 awaiting
);

  localparam int NR = NUM_ROUTERS_DEF;

  logic [ENTRY_W-1:0] path_cost [NR][NR];
  logic [FIELD_W-1:0] own_id;
  res_t               route_q [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  function automatic void clear_table();
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NR; c++) begin
        path_cost[r][c] = (r == c) ? '0 : INF_ENTRY;
      end
    end
  endfunction

  // bellman-ford pass over the own row, using only the row as it stood before
  function automatic void relax_own_row();
    int          me;
    int unsigned best;
    int unsigned via;
    int unsigned prior [NR];
    me = int'(own_id);
    for (int c = 0; c < NR; c++) prior[c] = 32'(path_cost[me][c]);
    for (int i = 0; i < NR; i++) begin
      if (i != me) begin
        best = prior[i];
        for (int j = 0; j < NR; j++) begin
          if (j != me) begin
            via = int'(path_cost[j][i]) + prior[j];
            if (via < best) best = via;
          end
        end
        path_cost[me][i] = best[ENTRY_W-1:0];
      end
    end
  endfunction

  // first router on a shortest path; search direction depends on where the destination lies
  function automatic logic [FIELD_W-1:0] first_hop(int dest);
    int me;
    int target;
    int r;
    me     = int'(own_id);
    target = int'(path_cost[me][dest]);
    if (dest == me) return dest[FIELD_W-1:0];
    for (int k = 0; k < NR; k++) begin
      r = (dest > me) ? k : NR - 1 - k;
      if (r != me && r != dest &&
          int'(path_cost[r][dest]) + int'(path_cost[me][r]) == target)
        return r[FIELD_W-1:0];
    end
    return dest[FIELD_W-1:0];
  endfunction

  function automatic void predict(cmd_t c);
    res_t r;
    case (c.opcode)
      OP_LINK: begin
        if (c.idx != own_id) path_cost[own_id][c.idx] = ENTRY_W'(c.cost);
      end
      OP_VECTOR: begin
        if (c.src != own_id) begin
          path_cost[c.src][c.idx] = ENTRY_W'(c.cost);
          if (c.last) begin
            relax_own_row();
            r.kind     = KIND_DONE;
            r.hop      = '0;
            r.distance = '0;
            route_q.push_back(r);
          end
        end
      end
      OP_QUERY: begin
        r.kind     = KIND_ROUTE;
        r.hop      = first_hop(int'(c.idx));
        r.distance = path_cost[own_id][c.idx][COST_W-1:0];
        route_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    cmd_t             c;
    res_t             want;
    logic [COST_W-1:0] raw;
    if (!rst_n) begin
      clear_table();
      own_id = '0;
      route_q.delete();
    end else begin
      if (cfg_wr_en) own_id = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        raw      = in_tdata[15:6];
        c.opcode = in_tuser;
        c.src    = in_tdata[2:0];
        c.idx    = in_tdata[5:3];
        c.cost   = (raw > INF_COST) ? INF_COST : raw;
        c.last   = in_tlast;
        predict(c);
      end
      if (out_tvalid && out_tready) begin
        if (route_q.size() == 0) begin
          $error("result transaction with nothing expected: kind %0d hop %0d distance %0d",
                 out_tuser, out_tdata[2:0], out_tdata[12:3]);
          mismatches++;
        end else begin
          want = route_q.pop_front();
          if (out_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
            mismatches++;
          end
          if (out_tdata[2:0] !== want.hop) begin
            $error("next_hop: expected %0d, got %0d", want.hop, out_tdata[2:0]);
            mismatches++;
          end
          if (out_tdata[12:3] !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_tdata[12:3]);
            mismatches++;
          end
          if (out_tdata[15:13] !== 3'b000) begin
            $error("pad: expected 0, got %0d", out_tdata[15:13]);
            mismatches++;
          end
        end
      end
    end
    awaiting = route_q.size();
  end

endmodule

/* bench/testbench.sv */
// testbench: drives link costs, neighbour vectors and route queries into the route engine
// under several own_id settings with random gaps and stalls; depends on dvr_pkg,
// distance_vector_route_engine and dvr_route_checker
module testbench;
  import dvr_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         SETTLE      = 100;
  localparam int         PHASE_ITEMS = 325;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata    = '0;   // source_router, entry_index, cost
  logic               in_tlast    = 1'b0; // last_entry
  logic [1:0]         in_tuser    = '0;   // opcode
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [15:0]        out_tdata;          // next_hop, distance, zero pad
  logic               out_tuser;          // result_kind
  logic               cfg_wr_en   = 1'b0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;   // own_id

  int                 mismatches;
  int                 awaiting;
  int                 idle_cycles = 0;
  int                 stall_left  = 0;
  bit                 steady_out  = 1'b0;
  bit                 steady_in   = 1'b0;
  logic [FIELD_W-1:0] own_now     = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  distance_vector_route_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dvr_route_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // costs kept small so that ties and shorter paths turn up often
  function automatic logic [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return COST_W'($urandom_range(0, 15));
    if (r < 75) return COST_W'($urandom_range(16, 200));
    if (r < 85) return INF_COST;
    if (r < 93) return COST_W'($urandom_range(1001, 1023));
    return COST_W'($urandom_range(0, 1023));
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!steady_out) stall_left <= pause_len();
    end
    if ($urandom_range(0, 299) == 0) steady_out <= !steady_out;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // entered and left just after a rising edge; valid stays high between back-to-back items
  task automatic send_cmd(input logic [1:0] op, input logic [FIELD_W-1:0] src,
                          input logic [FIELD_W-1:0] idx, input logic [COST_W-1:0] cost,
                          input logic last);
    int gap;
    gap = steady_in ? 0 : pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {cost, idx, src};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_own_id(input logic [FIELD_W-1:0] id);
    wait_drained();
    // an entry that yields no result may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_now   =  id;
  endtask

  task automatic random_traffic(input int goal);
    int                 done;
    int                 r;
    int                 len;
    bit                 broken;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] idx;
    done = 0;
    while (done < goal) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) steady_in = !steady_in;
      if (r < 12) begin
        idx = FIELD_W'($urandom_range(0, 7));
        send_cmd(OP_LINK, FIELD_W'($urandom_range(0, 7)), idx, pick_cost(),
                 1'($urandom_range(0, 1)));
        if (idx != own_now) done++;
      end else if (r < 30) begin
        send_cmd(OP_QUERY, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom_range(0, 7)),
                 COST_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        done++;
      end else if (r < 32) begin
        send_cmd(OP_SPARE, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom_range(0, 7)),
                 COST_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end else if (r < 34) begin
        send_cmd(OP_VECTOR, own_now, FIELD_W'($urandom_range(0, 7)), pick_cost(),
                 1'($urandom_range(0, 1)));
      end else if (r < 36) begin
        wait_drained();
      end else begin
        do src = FIELD_W'($urandom_range(0, 7)); while (src == own_now);
        len    = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          send_cmd(OP_VECTOR, src, FIELD_W'($urandom_range(0, 7)), pick_cost(),
                   (k == len - 1) && !broken);
        end
        done += len;
      end
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] later_ids [5];
    later_ids = '{3'd3, 3'd0, FIELD_W'($urandom_range(1, 6)),
                  FIELD_W'($urandom_range(0, 7)), 3'd5};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_own_id(3'd0);

    send_cmd(OP_LINK,   3'd0, 3'd1, 10'd0,    1'b0);
    send_cmd(OP_LINK,   3'd5, 3'd2, 10'd7,    1'b1);
    send_cmd(OP_LINK,   3'd0, 3'd3, 10'd1023, 1'b0);
    send_cmd(OP_LINK,   3'd0, 3'd7, 10'd1001, 1'b0);
    send_cmd(OP_LINK,   3'd0, 3'd0, 10'd9,    1'b0);  // own diagonal, left alone
    send_cmd(OP_LINK,   3'd0, 3'd4, INF_COST, 1'b0);
    send_cmd(OP_VECTOR, 3'd0, 3'd2, 10'd3,    1'b1);  // vector from ourselves
    send_cmd(OP_VECTOR, 3'd1, 3'd2, 10'd4,    1'b0);
    send_cmd(OP_VECTOR, 3'd1, 3'd3, INF_COST, 1'b0);
    send_cmd(OP_VECTOR, 3'd1, 3'd7, 10'd0,    1'b1);
    send_cmd(OP_VECTOR, 3'd7, 3'd7, 10'd1023, 1'b1);
    send_cmd(OP_SPARE,  3'd7, 3'd7, 10'd1023, 1'b1);
    send_cmd(OP_QUERY,  3'd0, 3'd0, 10'd0,    1'b0);
    send_cmd(OP_QUERY,  3'd7, 3'd2, 10'd1023, 1'b1);
    send_cmd(OP_QUERY,  3'd0, 3'd7, 10'd0,    1'b0);
    send_cmd(OP_QUERY,  3'd0, 3'd4, 10'd0,    1'b0);
    send_cmd(OP_QUERY,  3'd0, 3'd3, 10'd0,    1'b0);

    write_own_id(3'd7);
    send_cmd(OP_LINK,   3'd0, 3'd6, 10'd2,    1'b0);
    send_cmd(OP_VECTOR, 3'd6, 3'd0, 10'd1,    1'b1);
    send_cmd(OP_QUERY,  3'd0, 3'd0, 10'd0,    1'b0);  // below own_id, searched downward
    send_cmd(OP_QUERY,  3'd0, 3'd6, 10'd0,    1'b0);
    random_traffic(PHASE_ITEMS);

    foreach (later_ids[p]) begin
      write_own_id(later_ids[p]);
      random_traffic(PHASE_ITEMS);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    if (awaiting != 0) $error("%0d expected results never arrived", awaiting);
    if (mismatches == 0 && awaiting == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
